### design/euler_angles_to_basis_vectors_core_macros.svh
// assertion macros for the euler angle core top level
// depends on nothing
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_CORE_MACROS_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define EAB_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// implication checked in the cycle after its antecedent
`define EAB_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

### design/eab_pkg.sv
// shared types and constants for the euler angle to basis vector core
// depends on nothing
package eab_pkg;
   // internal fixed point is signed two's complement Q30 in 32 bits
   localparam int QW = 32;
   typedef logic signed [QW-1:0] q30_type;
   typedef logic [31:0] pi_type;
   localparam pi_type PI_Q30 = 32'hC90FDAA2;
   localparam logic [30:0] Q_ONE = 31'h40000000;
   // horner stage count
   localparam int HSTEPS = 6;
   typedef logic [7:0] div_type;
   function automatic div_type sin_div(input int i);
      case (i)
         0: sin_div = 8'd156;
         1: sin_div = 8'd110;
         2: sin_div = 8'd72;
         3: sin_div = 8'd42;
         4: sin_div = 8'd20;
         default: sin_div = 8'd6;
      endcase
   endfunction
   function automatic div_type cos_div(input int i);
      case (i)
         0: cos_div = 8'd132;
         1: cos_div = 8'd90;
         2: cos_div = 8'd56;
         3: cos_div = 8'd30;
         4: cos_div = 8'd12;
         default: cos_div = 8'd2;
      endcase
   endfunction
   // signed Q30 product, rounded to nearest with halves away from zero
   function automatic q30_type mul_q30(input q30_type a, input q30_type b);
      logic [QW-1:0] ua, ub;
      logic [2*QW-1:0] p;
      logic [QW-1:0] m;
      ua = a[QW-1] ? QW'(-a) : QW'(a);
      ub = b[QW-1] ? QW'(-b) : QW'(b);
      p = ua * ub + (64'd1 << 29);
      m = p[30+QW-1:30];
      mul_q30 = (a[QW-1] != b[QW-1]) ? q30_type'(-m) : q30_type'(m);
   endfunction
endpackage

### design/eab_horner_step.sv
// one horner step of the octant sine or cosine series, two register stages
// depends on eab_pkg
module eab_horner_step #(
   parameter int K = 2
) (
   input  logic        clock,
   input  logic [31:0] x2,
   input  logic [31:0] t,
   output logic [31:0] t_out
);
   import eab_pkg::*;
   // floor(n / K) for n below 2^30 as (n * RECIP) >> RSH, exact over that range
   localparam int RSH = 30 + $clog2(K);
   localparam logic [63:0] RECIP = ((64'd1 << RSH) + 64'(K) - 64'd1) / 64'(K);
   logic [63:0] prod;
   logic [29:0] n_in;
   logic [29:0] n_ff;
   logic [60:0] qp;
   logic [29:0] quot;
   logic [31:0] t_in;
   logic [31:0] t_ff;
   assign prod = 64'(x2) * 64'(t);
   assign n_in = prod[59:30];
   assign qp   = 61'(n_ff) * 61'(RECIP[30:0]);
   assign quot = 30'(qp >> RSH);
   assign t_in = 32'({1'b0, Q_ONE}) - 32'(quot);
   always_ff @(posedge clock) begin
      n_ff <= n_in;
      t_ff <= t_in;
   end
   assign t_out = t_ff;
endmodule

### design/eab_sincos.sv
// pipelined sine and cosine of a binary angle in Q30
// depends on eab_pkg and eab_horner_step
module eab_sincos #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_in,
   input  logic [ANGLE_BITS-1:0] angle,
   output eab_pkg::q30_type      sin_out,
   output eab_pkg::q30_type      cos_out,
   output logic                  valid_out
);
   import eab_pkg::*;
   localparam int RB = ANGLE_BITS - 2;
   // each horner step holds two register stages
   localparam int HLAT = 2 * HSTEPS;
   localparam int LAT = HLAT + 3;
   logic [RB-1:0] r;
   logic [RB:0]   ro;
   logic          fold;
   logic [RB+32:0] radp;
   logic [31:0]   x_in, x_ff, x2_ff, xd_ff;
   logic [63:0]   sq;
   logic [1:0]    q_ff [LAT];
   logic          f_ff [LAT];
   logic [31:0]   xs_ff [HLAT];
   logic [31:0]   x2s_ff [HLAT-2];
   logic [31:0]   ts [HSTEPS+1];
   logic [31:0]   tc [HSTEPS+1];
   logic          vh_ff [HLAT];
   logic          v0_ff, v1_ff, v2_ff, v3_ff;
   logic [63:0]   sp;
   logic [31:0]   s0_ff, c0_ff;
   logic [31:0]   s0, c0;
   q30_type       s_in, c_in, s_ff, c_ff;
   assign r    = angle[RB-1:0];
   assign fold = {1'b0, r} > ((RB+1)'(1) << (RB-1));
   assign ro   = fold ? (((RB+1)'(1) << RB) - (RB+1)'(r)) : (RB+1)'(r);
   assign radp = (RB+33)'(ro) * (RB+33)'(PI_Q30) + ((RB+33)'(1) << RB);
   assign x_in = radp[ANGLE_BITS-1 +: 32];
   assign sq   = 64'(x_ff) * 64'(x_ff) + (64'd1 << 29);
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      q_ff[0] <= angle[ANGLE_BITS-1 -: 2];
      f_ff[0] <= fold;
      x2_ff   <= sq[61:30];
      xd_ff   <= x_ff;
      for (int i = 1; i < LAT; i++) begin
         q_ff[i] <= q_ff[i-1];
         f_ff[i] <= f_ff[i-1];
      end
      xs_ff[0] <= xd_ff;
      for (int i = 1; i < HLAT; i++) xs_ff[i] <= xs_ff[i-1];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int i = 0; i < HLAT; i++) vh_ff[i] <= 1'b0;
      end else begin
         v0_ff    <= valid_in;
         v1_ff    <= v0_ff;
         vh_ff[0] <= v1_ff;
         for (int i = 1; i < HLAT; i++) vh_ff[i] <= vh_ff[i-1];
         v2_ff    <= vh_ff[HLAT-1];
         v3_ff    <= v2_ff;
      end
   end
   assign ts[0] = {1'b0, Q_ONE};
   assign tc[0] = {1'b0, Q_ONE};
   // x2 is held across the horner chain, two stages per step
   always_ff @(posedge clock) begin
      x2s_ff[0] <= x2_ff;
      for (int i = 1; i < HLAT-2; i++) x2s_ff[i] <= x2s_ff[i-1];
   end
   for (genvar g = 0; g < HSTEPS; g++) begin : g_h
      logic [31:0] x2g;
      if (g == 0) begin : g_first
         assign x2g = x2_ff;
      end else begin : g_rest
         assign x2g = x2s_ff[2*g-1];
      end
      eab_horner_step #(.K(int'(sin_div(g)))) u_s (
         .clock(clock), .x2(x2g), .t(ts[g]), .t_out(ts[g+1]));
      eab_horner_step #(.K(int'(cos_div(g)))) u_c (
         .clock(clock), .x2(x2g), .t(tc[g]), .t_out(tc[g+1]));
   end
   assign sp = 64'(xs_ff[HLAT-1]) * 64'(ts[HSTEPS]);
   always_ff @(posedge clock) begin
      s0_ff <= sp[61:30];
      c0_ff <= tc[HSTEPS];
   end
   assign s0 = f_ff[LAT-1] ? c0_ff : s0_ff;
   assign c0 = f_ff[LAT-1] ? s0_ff : c0_ff;
   always_comb begin
      case (q_ff[LAT-1])
         2'd0: begin s_in = q30_type'(s0);  c_in = q30_type'(c0);  end
         2'd1: begin s_in = q30_type'(c0);  c_in = -q30_type'(s0); end
         2'd2: begin s_in = -q30_type'(s0); c_in = -q30_type'(c0); end
         default: begin s_in = -q30_type'(c0); c_in = q30_type'(s0); end
      endcase
   end
   always_ff @(posedge clock) begin
      s_ff <= s_in;
      c_ff <= c_in;
   end
   assign sin_out   = s_ff;
   assign cos_out   = c_ff;
   assign valid_out = v3_ff;
endmodule

### design/eab_combine.sv
// products of sines and cosines into the nine basis components
// depends on eab_pkg
module eab_combine #(
   parameter int RESULT_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           valid_in,
   input  eab_pkg::q30_type               sp, cp, sy, cy, sr, cr,
   output logic                           valid_out,
   output logic signed [RESULT_BITS-1:0]  res [9]
);
   import eab_pkg::*;
   localparam int SH = 31 - RESULT_BITS;
   q30_type srsp_ff, crsp_ff, cy1_ff, sy1_ff, cr1_ff, sr1_ff, cp1_ff, sp1_ff;
   q30_type p_ff [10];
   logic signed [33:0] v_ff [9];
   logic signed [RESULT_BITS-1:0] o_ff [9];
   logic vld_ff [3];
   // single products and the negation of sp along the side path, two stages
   q30_type mz_ff, m5_ff, m8_ff;
   always_ff @(posedge clock) begin
      srsp_ff <= mul_q30(sr, sp);
      crsp_ff <= mul_q30(cr, sp);
      cy1_ff <= cy; sy1_ff <= sy; cr1_ff <= cr; sr1_ff <= sr; cp1_ff <= cp;
      sp1_ff <= sp;
      p_ff[0] <= mul_q30(cp1_ff, cy1_ff);
      p_ff[1] <= mul_q30(cp1_ff, sy1_ff);
      p_ff[2] <= mul_q30(srsp_ff, cy1_ff);
      p_ff[3] <= mul_q30(cr1_ff, sy1_ff);
      p_ff[4] <= mul_q30(srsp_ff, sy1_ff);
      p_ff[5] <= mul_q30(cr1_ff, cy1_ff);
      p_ff[6] <= mul_q30(crsp_ff, cy1_ff);
      p_ff[7] <= mul_q30(sr1_ff, sy1_ff);
      p_ff[8] <= mul_q30(crsp_ff, sy1_ff);
      p_ff[9] <= mul_q30(sr1_ff, cy1_ff);
      v_ff[0] <= 34'(p_ff[0]);
      v_ff[1] <= 34'(p_ff[1]);
      v_ff[2] <= 34'(mz_ff);
      v_ff[3] <= 34'(p_ff[3]) - 34'(p_ff[2]);
      v_ff[4] <= -34'(p_ff[4]) - 34'(p_ff[5]);
      v_ff[5] <= 34'(m5_ff);
      v_ff[6] <= 34'(p_ff[6]) + 34'(p_ff[7]);
      v_ff[7] <= 34'(p_ff[8]) - 34'(p_ff[9]);
      v_ff[8] <= 34'(m8_ff);
   end
   always_ff @(posedge clock) begin
      mz_ff <= -sp1_ff;
      m5_ff <= -mul_q30(sr1_ff, cp1_ff);
      m8_ff <= mul_q30(cr1_ff, cp1_ff);
   end
   function automatic logic signed [RESULT_BITS-1:0] to_res(input logic signed [33:0] v);
      logic [33:0] m;
      logic [66:0] w;
      logic [66:0] maxv;
      maxv = (67'd1 << (RESULT_BITS-1)) - 67'd1;
      m = v[33] ? 34'(-v) : 34'(v);
      if (SH > 0) w = (67'(m) + (67'd1 << (SH > 0 ? SH-1 : 0))) >> (SH > 0 ? SH : 0);
      else w = 67'(m) << (SH < 0 ? -SH : 0);
      if (v[33]) to_res = (w > maxv + 67'd1) ? RESULT_BITS'(maxv + 67'd1)
                                             : RESULT_BITS'(-w);
      else to_res = (w > maxv) ? RESULT_BITS'(maxv) : RESULT_BITS'(w);
   endfunction
   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) o_ff[i] <= to_res(v_ff[i]);
   end
   always_ff @(posedge clock) begin
      if (reset) for (int i = 0; i < 3; i++) vld_ff[i] <= 1'b0;
      else begin
         vld_ff[0] <= valid_in;
         vld_ff[1] <= vld_ff[0];
         vld_ff[2] <= vld_ff[1];
      end
   end
   logic vo_ff;
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else vo_ff <= vld_ff[2];
   end
   assign valid_out = vo_ff;
   assign res = o_ff;
endmodule

### design/euler_angles_to_basis_vectors_core.sv
// euler angles to forward, right and up unit vectors, top level
// depends on eab_pkg, eab_sincos, eab_combine and the macro header
//
// usage: drive req_pitch_angle, req_yaw_angle, req_roll_angle with start high;
// a transfer happens at a clock edge with start high and busy low. busy is
// always low, so one item is taken every cycle.
// the accepting edge loads the first of sixteen register stages of the sine and
// cosine pipeline (angle to radians, square, six horner steps of two stages
// each, sine product, quadrant fixup), then four stages of product, sum and
// rounding follow.
// throughput: one item per cycle.
// each result stands on the rsp_ ports for one cycle with done high and is taken
// at the edge that ends that cycle; the receiver cannot stall.
// reset: synchronous, active high; it clears all valid bits, so no result
// appears until new items are accepted.
module euler_angles_to_basis_vectors_core #(
   parameter int ANGLE_BITS  = 16,
   parameter int RESULT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [ANGLE_BITS-1:0]  req_pitch_angle,
   input  logic signed [ANGLE_BITS-1:0]  req_yaw_angle,
   input  logic signed [ANGLE_BITS-1:0]  req_roll_angle,
   output logic                          done,
   output logic signed [RESULT_BITS-1:0] rsp_forward_x,
   output logic signed [RESULT_BITS-1:0] rsp_forward_y,
   output logic signed [RESULT_BITS-1:0] rsp_forward_z,
   output logic signed [RESULT_BITS-1:0] rsp_right_x,
   output logic signed [RESULT_BITS-1:0] rsp_right_y,
   output logic signed [RESULT_BITS-1:0] rsp_right_z,
   output logic signed [RESULT_BITS-1:0] rsp_up_x,
   output logic signed [RESULT_BITS-1:0] rsp_up_y,
   output logic signed [RESULT_BITS-1:0] rsp_up_z
);
   import eab_pkg::*;
   `include "euler_angles_to_basis_vectors_core_macros.svh"
   q30_type sp, cp, sy, cy, sr, cr;
   logic vp, vy, vr, vout;
   logic signed [RESULT_BITS-1:0] res [9];
   logic acc;
   assign busy = 1'b0;
   assign acc  = start && !busy;
   eab_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_p (
      .clock(clock), .reset(reset), .valid_in(acc), .angle(req_pitch_angle),
      .sin_out(sp), .cos_out(cp), .valid_out(vp));
   eab_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_y (
      .clock(clock), .reset(reset), .valid_in(acc), .angle(req_yaw_angle),
      .sin_out(sy), .cos_out(cy), .valid_out(vy));
   eab_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_r (
      .clock(clock), .reset(reset), .valid_in(acc), .angle(req_roll_angle),
      .sin_out(sr), .cos_out(cr), .valid_out(vr));
   eab_combine #(.RESULT_BITS(RESULT_BITS)) u_c (
      .clock(clock), .reset(reset), .valid_in(vp),
      .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
      .valid_out(vout), .res(res));
   assign done          = vout;
   assign rsp_forward_x = res[0];
   assign rsp_forward_y = res[1];
   assign rsp_forward_z = res[2];
   assign rsp_right_x   = res[3];
   assign rsp_right_y   = res[4];
   assign rsp_right_z   = res[5];
   assign rsp_up_x      = res[6];
   assign rsp_up_y      = res[7];
   assign rsp_up_z      = res[8];
   `EAB_ASSERT_IMPL(a_lanes_agree, clock, reset, 1'b1, (vp == vy) && (vy == vr))
   `EAB_ASSERT_NEXT(a_no_busy, clock, reset, start, !busy)
   `EAB_ASSERT_IMPL(a_done_origin, clock, reset, done, $past(vp, 4))
endmodule
